// ===== design/ppts_pkg.sv =====
package ppts_pkg;

	localparam int DEF_NUM_SLOTS  = 8;
	localparam int DEF_COUNT_BITS = 16;

	localparam int ENTRY_W  = 32;
	localparam int PERIOD_W = 16;
	localparam int PRIO_W   = 8;
	localparam int CMD_W    = 2;

	typedef logic signed [PRIO_W-1:0] prio_t;
	typedef logic [1:0] status_t;
	typedef logic [CMD_W-1:0] cmd_t;

	localparam status_t ST_EMPTY     = 2'd0;
	localparam status_t ST_STOPPED   = 2'd1;
	localparam status_t ST_SUSPENDED = 2'd2;
	localparam status_t ST_RUNNING   = 2'd3;

	localparam cmd_t CMD_TICK   = 2'd0;
	localparam cmd_t CMD_ADD    = 2'd1;
	localparam cmd_t CMD_FINISH = 2'd2;

	localparam prio_t PRIO_IDLE = -8'sd1;
	localparam prio_t PRIO_MIN  = 8'sd1;
	localparam prio_t PRIO_MAX  = 8'sd127;

	localparam logic ADDR_IDLE_ENTRY = 1'b0;

	typedef struct packed {
		logic tick;
		logic add_we;
		logic make_run;
		logic make_susp;
		logic make_stop;
	} cell_ctl_t;

endpackage

// ===== design/ppts_cell.sv =====
module ppts_cell
	import ppts_pkg::*;
#(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int IDX        = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic [ENTRY_W-1:0]           add_entry,
	input  logic [COUNT_BITS-1:0]        add_period,
	input  prio_t                        add_prio,
	input  prio_t                        in_prio,
	input  logic [$clog2(NUM_SLOTS)-1:0] in_idx,
	input  logic [ENTRY_W-1:0]           in_entry,
	input  logic                         in_free_found,
	input  logic [$clog2(NUM_SLOTS)-1:0] in_free_idx,
	output prio_t                        out_prio,
	output logic [$clog2(NUM_SLOTS)-1:0] out_idx,
	output logic [ENTRY_W-1:0]           out_entry,
	output logic                         out_free_found,
	output logic [$clog2(NUM_SLOTS)-1:0] out_free_idx
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);
	localparam logic IS_TASK = (IDX != 0);

	status_t                 status_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [COUNT_BITS-1:0]   period_q;
	prio_t                   prio_q;
	logic [ENTRY_W-1:0]      entry_q;

	prio_t                   cand_prio_q;
	logic [SLOT_W-1:0]       cand_idx_q;
	logic [ENTRY_W-1:0]      cand_entry_q;
	logic                    free_found_q;
	logic [SLOT_W-1:0]       free_idx_q;

	logic                    wrap;
	logic [COUNT_BITS-1:0]   count_inc;
	logic                    active;
	logic                    take;
	logic                    claim;

	assign count_inc = count_q + COUNT_BITS'(1);
	assign wrap      = ({1'b0, count_q} + {{COUNT_BITS{1'b0}}, 1'b1}) == {1'b0, period_q};
	assign active    = (status_q == ST_RUNNING) || (status_q == ST_SUSPENDED);
	assign take      = active && (prio_q > in_prio);
	assign claim     = IS_TASK && !in_free_found && (status_q == ST_EMPTY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= IS_TASK ? ST_EMPTY : ST_RUNNING;
			count_q  <= '0;
			period_q <= COUNT_BITS'(1);
			prio_q   <= PRIO_IDLE;
		end else if (ctl.tick && IS_TASK) begin
			count_q <= wrap ? '0 : count_inc;
			if (wrap && status_q == ST_STOPPED) begin
				status_q <= ST_SUSPENDED;
			end
		end else if (ctl.add_we && IS_TASK) begin
			status_q <= ST_STOPPED;
			count_q  <= '0;
			period_q <= add_period;
			prio_q   <= add_prio;
		end else if (ctl.make_run) begin
			status_q <= ST_RUNNING;
		end else if (ctl.make_susp) begin
			if (status_q == ST_RUNNING) begin
				status_q <= ST_SUSPENDED;
			end
		end else if (ctl.make_stop && IS_TASK) begin
			status_q <= ST_STOPPED;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_we) begin
			entry_q <= add_entry;
		end
	end

	// candidate moves one cell per cycle
	always_ff @(posedge clk) begin
		if (take) begin
			cand_prio_q  <= prio_q;
			cand_idx_q   <= MY_IDX;
			cand_entry_q <= entry_q;
		end else begin
			cand_prio_q  <= in_prio;
			cand_idx_q   <= in_idx;
			cand_entry_q <= in_entry;
		end
		free_found_q <= in_free_found || claim;
		free_idx_q   <= claim ? MY_IDX : in_free_idx;
	end

	assign out_prio       = cand_prio_q;
	assign out_idx        = cand_idx_q;
	assign out_entry      = cand_entry_q;
	assign out_free_found = free_found_q;
	assign out_free_idx   = free_idx_q;

endmodule

// ===== design/periodic_priority_task_scheduler.sv =====
// Fixed-priority periodic scheduler over NUM_SLOTS task slots, slot 0 being the idle task.
// Each slot lives in one cell of a chain; a tick updates every task cell's count at once, then a
// best-priority and first-free-slot candidate walks down the chain one cell per cycle. An item
// is searched while the candidate crosses the whole cell chain, and its result is committed to
// the output register once that register is free; one item is worked on at a time, and the next
// may be accepted while the previous result still waits in the output register.
module periodic_priority_task_scheduler
	import ppts_pkg::*;
#(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [CMD_W-1:0]             cmd,
	input  logic [ENTRY_W-1:0]           entry_address,
	input  logic [PERIOD_W-1:0]          period,
	input  logic [PRIO_W-1:0]            priority_req,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         switched,
	output logic [$clog2(NUM_SLOTS)-1:0] run_slot,
	output logic [ENTRY_W-1:0]           run_entry_address,
	output logic [$clog2(NUM_SLOTS)-1:0] added_slot,
	output logic                         table_full
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_SEARCH = 1'b1;

	logic                  state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ENTRY_W-1:0]    idle_entry_q;
	logic [SLOT_W-1:0]     cur_q;
	logic [ENTRY_W-1:0]    cur_entry_q;

	cmd_t                  cmd_q;
	logic [ENTRY_W-1:0]    add_entry_q;
	logic [COUNT_BITS-1:0] add_period_q;
	prio_t                 add_prio_q;

	logic                  out_valid_q;
	logic                  switched_q;
	logic [SLOT_W-1:0]     run_slot_q;
	logic [ENTRY_W-1:0]    run_entry_q;
	logic [SLOT_W-1:0]     added_slot_q;
	logic                  table_full_q;

	logic                  in_acc;
	logic                  cfg_wr;
	logic                  commit;
	logic [COUNT_BITS-1:0] period_clip;
	logic [COUNT_BITS-1:0] period_sat;
	prio_t                 prio_sat;

	prio_t                 ch_prio  [NUM_SLOTS+1];
	logic [SLOT_W-1:0]     ch_idx   [NUM_SLOTS+1];
	logic [ENTRY_W-1:0]    ch_entry [NUM_SLOTS+1];
	logic                  ch_found [NUM_SLOTS+1];
	logic [SLOT_W-1:0]     ch_free  [NUM_SLOTS+1];

	cell_ctl_t             ctl [NUM_SLOTS];

	logic [SLOT_W-1:0]     pick;
	logic [ENTRY_W-1:0]    pick_entry;
	logic                  free_found;
	logic [SLOT_W-1:0]     free_idx;
	logic                  do_switch;
	logic                  do_add;
	logic                  do_stop;
	logic [SLOT_W-1:0]     new_cur;
	logic [ENTRY_W-1:0]    new_entry;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ADDR_IDLE_ENTRY);
	assign prdata   = (paddr[2] == ADDR_IDLE_ENTRY) ? idle_entry_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_entry_q <= '0;
		end else if (cfg_wr) begin
			idle_entry_q <= pwdata;
		end
	end

	generate
		if (COUNT_BITS >= PERIOD_W) begin : g_period_wide
			assign period_clip = COUNT_BITS'(period);
		end else begin : g_period_narrow
			assign period_clip = (|period[PERIOD_W-1:COUNT_BITS]) ? '1 :
				period[COUNT_BITS-1:0];
		end
	endgenerate

	assign period_sat = (period_clip == '0) ? COUNT_BITS'(1) : period_clip;

	always_comb begin
		if (priority_req == '0) begin
			prio_sat = PRIO_MIN;
		end else if (priority_req[PRIO_W-1]) begin
			prio_sat = PRIO_MAX;
		end else begin
			prio_sat = prio_t'(priority_req);
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign commit   = (state_q == S_SEARCH) && (cnt_q == CNT_W'(NUM_SLOTS)) &&
		(!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SEARCH;
						cnt_q   <= '0;
					end
				end
				S_SEARCH: begin
					if (commit) begin
						state_q <= S_IDLE;
					end else if (cnt_q != CNT_W'(NUM_SLOTS)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q        <= cmd;
			add_entry_q  <= entry_address;
			add_period_q <= period_sat;
			add_prio_q   <= prio_sat;
		end
	end

	assign ch_prio[0]  = PRIO_IDLE;
	assign ch_idx[0]   = '0;
	assign ch_entry[0] = '0;
	assign ch_found[0] = 1'b0;
	assign ch_free[0]  = '0;

	assign pick       = ch_idx[NUM_SLOTS];
	assign pick_entry = ch_entry[NUM_SLOTS];
	assign free_found = ch_found[NUM_SLOTS];
	assign free_idx   = ch_free[NUM_SLOTS];

	assign do_switch = commit && (cmd_q == CMD_TICK) && (pick != cur_q);
	assign do_add    = commit && (cmd_q == CMD_ADD) && free_found;
	assign do_stop   = commit && (cmd_q == CMD_FINISH) && (cur_q != '0);
	assign new_cur   = do_switch ? pick : cur_q;
	assign new_entry = do_switch ? pick_entry : cur_entry_q;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
			always_comb begin
				ctl[gi].tick      = in_acc && (cmd == CMD_TICK);
				ctl[gi].add_we    = do_add && (free_idx == SLOT_W'(gi));
				ctl[gi].make_run  = do_switch && (pick == SLOT_W'(gi));
				ctl[gi].make_susp = do_switch && (cur_q == SLOT_W'(gi));
				ctl[gi].make_stop = do_stop && (cur_q == SLOT_W'(gi));
			end

			ppts_cell #(
				.NUM_SLOTS (NUM_SLOTS),
				.COUNT_BITS(COUNT_BITS),
				.IDX       (gi)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (ctl[gi]),
				.add_entry     (add_entry_q),
				.add_period    (add_period_q),
				.add_prio      (add_prio_q),
				.in_prio       (ch_prio[gi]),
				.in_idx        (ch_idx[gi]),
				.in_entry      (ch_entry[gi]),
				.in_free_found (ch_found[gi]),
				.in_free_idx   (ch_free[gi]),
				.out_prio      (ch_prio[gi+1]),
				.out_idx       (ch_idx[gi+1]),
				.out_entry     (ch_entry[gi+1]),
				.out_free_found(ch_found[gi+1]),
				.out_free_idx  (ch_free[gi+1])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (do_switch) begin
			cur_q <= pick;
		end
	end

	always_ff @(posedge clk) begin
		if (do_switch) begin
			cur_entry_q <= pick_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			switched_q   <= do_switch;
			run_slot_q   <= new_cur;
			run_entry_q  <= (new_cur == '0) ? idle_entry_q : new_entry;
			added_slot_q <= do_add ? free_idx : '0;
			table_full_q <= (cmd_q == CMD_ADD) && !free_found;
		end
	end

	assign out_valid         = out_valid_q;
	assign switched          = switched_q;
	assign run_slot          = run_slot_q;
	assign run_entry_address = run_entry_q;
	assign added_slot        = added_slot_q;
	assign table_full        = table_full_q;

endmodule

// ===== design/ppts_checker.sv =====
module ppts_checker
	import ppts_pkg::*;
#(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         switched,
	input logic [$clog2(NUM_SLOTS)-1:0] run_slot,
	input logic [ENTRY_W-1:0]           run_entry_address,
	input logic [$clog2(NUM_SLOTS)-1:0] added_slot,
	input logic                         table_full
);

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous item in progress");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(run_slot) &&
		$stable(run_entry_address) && $stable(switched)))
		else $error("stalled result changed");

	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (added_slot == '0 && !switched))
		else $error("refused add reports a slot or a switch");

	a_add_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && added_slot != '0) |-> (!switched && !table_full))
		else $error("add item reports a switch or full table");

endmodule

bind periodic_priority_task_scheduler ppts_checker #(
	.NUM_SLOTS(NUM_SLOTS)
) u_ppts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.switched         (switched),
	.run_slot         (run_slot),
	.run_entry_address(run_entry_address),
	.added_slot       (added_slot),
	.table_full       (table_full)
);

// ===== tb/tb_periodic_priority_task_scheduler.sv =====
module tb_periodic_priority_task_scheduler
	import ppts_pkg::*;
();

	localparam int NSLOT = DEF_NUM_SLOTS;
	localparam int SLOT_W = $clog2(NSLOT);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam cmd_t CMD_UNUSED = 2'd3;

	typedef struct packed {
		cmd_t                cmd;
		logic [ENTRY_W-1:0]  entry;
		logic [PERIOD_W-1:0] period;
		logic [PRIO_W-1:0]   prio;
	} sched_item_t;

	typedef struct packed {
		logic               switched;
		logic [SLOT_W-1:0]  slot;
		logic [ENTRY_W-1:0] entry;
		logic [SLOT_W-1:0]  added;
		logic               full;
	} sched_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [CMD_W-1:0] cmd;
	logic [ENTRY_W-1:0] entry_address;
	logic [PERIOD_W-1:0] period;
	logic [PRIO_W-1:0] priority_req;
	logic out_valid, out_stall;
	logic switched;
	logic [SLOT_W-1:0] run_slot;
	logic [ENTRY_W-1:0] run_entry_address;
	logic [SLOT_W-1:0] added_slot;
	logic table_full;

	periodic_priority_task_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .entry_address(entry_address), .period(period),
		.priority_req(priority_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.switched(switched), .run_slot(run_slot), .run_entry_address(run_entry_address),
		.added_slot(added_slot), .table_full(table_full)
	);

	// scheduler state as predicted
	status_t slot_state [NSLOT];
	logic [PERIOD_W-1:0] slot_count [NSLOT];
	logic [PERIOD_W-1:0] slot_period [NSLOT];
	prio_t slot_prio [NSLOT];
	logic [ENTRY_W-1:0] slot_entry [NSLOT];
	logic [SLOT_W-1:0] running;
	logic [31:0] idle_entry_cfg;

	sched_item_t pending_items [$];
	sched_result_t expected_results [$];
	sched_item_t cur_item;
	sched_item_t seen_item;
	sched_result_t got_result;
	sched_result_t want_result;
	logic in_taken;
	int gap_left;
	int stall_left;
	int idle_cycles;
	int errors;
	bit quiet;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic void reset_model();
		for (int i = 0; i < NSLOT; i++) begin
			slot_state[i] = ST_EMPTY;
			slot_count[i] = '0;
			slot_period[i] = PERIOD_W'(1);
			slot_prio[i] = PRIO_IDLE;
			slot_entry[i] = '0;
		end
		slot_state[0] = ST_RUNNING;
		running = '0;
		idle_entry_cfg = '0;
	endfunction

	function automatic sched_result_t schedule_item(input sched_item_t it);
		sched_result_t res;
		int unsigned per;
		int unsigned cnt;
		int best;
		int best_prio;
		int free_slot;
		res = '0;
		case (it.cmd)
			CMD_TICK: begin
				for (int i = 1; i < NSLOT; i++) begin
					per = (slot_period[i] == 0) ? 1 : slot_period[i];
					cnt = (slot_count[i] + 1) % per;
					slot_count[i] = cnt[PERIOD_W-1:0];
					if (cnt == 0 && slot_state[i] == ST_STOPPED)
						slot_state[i] = ST_SUSPENDED;
				end
				best = 0;
				best_prio = -1;
				for (int i = 0; i < NSLOT; i++) begin
					if ((slot_state[i] == ST_RUNNING || slot_state[i] == ST_SUSPENDED) &&
							int'(slot_prio[i]) > best_prio) begin
						best_prio = int'(slot_prio[i]);
						best = i;
					end
				end
				if (best != running) begin
					if (slot_state[running] == ST_RUNNING)
						slot_state[running] = ST_SUSPENDED;
					slot_state[best] = ST_RUNNING;
					running = best[SLOT_W-1:0];
					res.switched = 1'b1;
				end
			end
			CMD_ADD: begin
				free_slot = 0;
				for (int i = 1; i < NSLOT; i++)
					if (free_slot == 0 && slot_state[i] == ST_EMPTY)
						free_slot = i;
				if (free_slot == 0) begin
					res.full = 1'b1;
				end else begin
					slot_state[free_slot] = ST_STOPPED;
					slot_entry[free_slot] = it.entry;
					slot_period[free_slot] = (it.period == '0) ? PERIOD_W'(1) : it.period;
					slot_count[free_slot] = '0;
					if (it.prio < PRIO_MIN)
						slot_prio[free_slot] = PRIO_MIN;
					else if (it.prio > PRIO_MAX)
						slot_prio[free_slot] = PRIO_MAX;
					else
						slot_prio[free_slot] = it.prio;
					res.added = free_slot[SLOT_W-1:0];
				end
			end
			CMD_FINISH: begin
				if (running != 0)
					slot_state[running] = ST_STOPPED;
			end
			default: begin
			end
		endcase
		res.slot = running;
		res.entry = (running == 0) ? idle_entry_cfg : slot_entry[running];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_item(input cmd_t c, input logic [31:0] e, input logic [15:0] p,
			input logic [7:0] pr);
		sched_item_t it;
		it.cmd = c;
		it.entry = e;
		it.period = p;
		it.prio = pr;
		pending_items.push_back(it);
	endtask

	task automatic push_random(input int n);
		int r;
		logic [15:0] p;
		cmd_t c;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				c = CMD_TICK;
			else if (r < 85)
				c = CMD_FINISH;
			else if (r < 93)
				c = CMD_ADD;
			else
				c = CMD_UNUSED;
			p = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8)) : 16'($urandom);
			push_item(c, $urandom, p, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idle_entry(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ADDR_IDLE_ENTRY, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value)
			report_mismatch("idle entry readback", prdata, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		idle_entry_cfg = value;
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					cmd <= cur_item.cmd;
					entry_address <= cur_item.entry;
					period <= cur_item.period;
					priority_req <= cur_item.prio;
					in_valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= pick_gap();
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				got_result = {switched, run_slot, run_entry_address, added_slot, table_full};
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", got_result.entry, '0);
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.switched !== want_result.switched)
						report_mismatch("switched", 32'(got_result.switched),
							32'(want_result.switched));
					if (got_result.slot !== want_result.slot)
						report_mismatch("run_slot", 32'(got_result.slot),
							32'(want_result.slot));
					if (got_result.entry !== want_result.entry)
						report_mismatch("run_entry_address", got_result.entry,
							want_result.entry);
					if (got_result.added !== want_result.added)
						report_mismatch("added_slot", 32'(got_result.added),
							32'(want_result.added));
					if (got_result.full !== want_result.full)
						report_mismatch("table_full", 32'(got_result.full),
							32'(want_result.full));
				end
			end
			if (in_valid && !in_stall) begin
				seen_item = {cmd, entry_address, period, priority_req};
				expected_results.push_back(schedule_item(seen_item));
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		entry_address = '0;
		period = '0;
		priority_req = '0;
		out_stall = 1'b0;
		in_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		errors = 0;
		quiet = 1'b0;
		reset_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle_entry(32'h0000_0000);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_FINISH, $urandom, 16'h0, 8'h0);
		push_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		push_item(CMD_ADD, 32'h0000_0000, 16'd0, 8'd0);
		push_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_ADD, $urandom, 16'd2, 8'd128);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_FINISH, $urandom, 16'h0, 8'h0);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_UNUSED, $urandom, 16'h0, 8'h0);
		push_item(CMD_FINISH, $urandom, 16'h0, 8'h0);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_ADD, $urandom, 16'd3, 8'd127);
		push_item(CMD_ADD, $urandom, 16'd1, 8'd1);
		push_item(CMD_ADD, $urandom, 16'd5, 8'd64);
		push_item(CMD_ADD, $urandom, 16'd4, 8'd64);
		push_item(CMD_ADD, $urandom, 16'd7, 8'd100);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_FINISH, $urandom, 16'h0, 8'h0);
		push_item(CMD_TICK, $urandom, 16'h0, 8'h0);
		push_item(CMD_FINISH, $urandom, 16'h0, 8'h0);
		wait_drained();

		set_idle_entry(32'hFFFF_FFFF);
		push_random(140);
		wait_drained();

		quiet = 1'b1;
		set_idle_entry($urandom);
		push_random(140);
		wait_drained();

		quiet = 1'b0;
		set_idle_entry(32'h0000_0000);
		push_random(140);
		wait_drained();

		set_idle_entry($urandom);
		push_random(130);
		wait_drained();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
